// ----- sv/cbz_pkg.sv -----
// Shared constants for the cubic Bezier point and tangent unit.
`timescale 1ns / 1ps

package cbz_pkg;

    // Configuration register map.
    localparam int NUM_CTRL_REGS = 8;
    localparam int CFG_INDEX_W   = 4;
    localparam int CTRL_SEL_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] CTRL_X0 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CTRL_Y0 = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CTRL_X1 = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CTRL_Y1 = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CTRL_X2 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CTRL_Y2 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CTRL_X3 = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CTRL_Y3 = 4'd7;

    // Pipeline depth from the parameter register to the output register.
    localparam int NUM_STAGES = 5;

endpackage

// ----- sv/cbz_lerp.sv -----
// Registered exact integer interpolation u*a + t*b with u + t = 2^F.
`timescale 1ns / 1ps

module cbz_lerp #(
    parameter int IN_W = 32,
    parameter int F    = 16
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic signed [IN_W-1:0] a_val,
    input  logic signed [IN_W-1:0] b_val,
    input  logic [F:0]             t_val,
    input  logic [F:0]             u_val,
    output logic signed [IN_W+F-1:0] q_val
);

    localparam int PW = IN_W + F + 2;

    logic signed [F+1:0]        t_s;
    logic signed [F+1:0]        u_s;
    logic signed [PW-1:0]       ua;
    logic signed [PW-1:0]       tb;
    logic signed [PW-1:0]       sum;
    logic signed [IN_W+F-1:0]   q_reg;

    assign t_s = signed'({1'b0, t_val});
    assign u_s = signed'({1'b0, u_val});

    always_comb
    begin
        ua  = PW'(a_val) * PW'(u_s);
        tb  = PW'(b_val) * PW'(t_s);
        sum = ua + tb;
    end

    // The weights sum to 2^F, so the result lies between a and b scaled by 2^F.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= sum[IN_W+F-1:0];
        end
    end

    assign q_val = q_reg;

endmodule

// ----- sv/cbz_round_sat.sv -----
// Divide by a power of two rounding half up, then clip to the output width.
`timescale 1ns / 1ps

module cbz_round_sat #(
    parameter int IN_W  = 80,
    parameter int SHIFT = 48,
    parameter int OUT_W = 32
) (
    input  logic signed [IN_W-1:0] value_in,
    output logic [OUT_W-1:0]       value_out,
    output logic                   clipped
);

    localparam int EW = IN_W + 1;

    localparam logic signed [EW-1:0] HALF =
        {{(EW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
    localparam logic signed [EW-1:0] MAXV =
        {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EW-1:0] MINV =
        {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [EW-1:0] rounded;
    logic signed [EW-1:0] shifted;
    logic                 above;
    logic                 below;

    always_comb
    begin
        rounded = EW'(value_in) + HALF;
        shifted = rounded >>> SHIFT;
        above   = shifted > MAXV;
        below   = shifted < MINV;
        clipped = above || below;
        if (above)
        begin
            value_out = OUT_MAX;
        end
        else if (below)
        begin
            value_out = OUT_MIN;
        end
        else
        begin
            value_out = shifted[OUT_W-1:0];
        end
    end

endmodule

// ----- sv/cubic_bezier_point_tangent_unit.sv -----
// Top level of the cubic Bezier point and tangent evaluator.
`timescale 1ns / 1ps

// Evaluates a 2D cubic Bezier curve and its derivative at a parameter t.
// The four control points are written over the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high and
// an index beyond the last register is ignored. Write them while idle.
// Each input transaction (in_valid, in_ready, param_t) carries t in
// unsigned Q1.F; values above 1.0 are clamped to 1.0. Each yields one output
// transaction (out_valid, out_ready) with point, tangent and a saturated flag.
// The datapath is an exact de Casteljau ladder: clamp, three interpolation
// levels and a round/clip stage, five register stages in all. An accepted
// item moves through the stage registers in order and out_valid rises when
// it reaches the last; one item is taken every cycle while in_ready is high.
// Each stage holds its item while the one after it is full and stalled, so
// bubbles close up and in_ready falls only when all five stages hold items
// and out_ready is low. Reset clears the control points to zero and empties
// the pipeline.
module cubic_bezier_point_tangent_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbz_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [T_FRAC_BITS:0]           param_t,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_WIDTH-1:0]         point_x,
    output logic [COORD_WIDTH-1:0]         point_y,
    output logic [COORD_WIDTH-1:0]         tangent_x,
    output logic [COORD_WIDTH-1:0]         tangent_y,
    output logic                           saturated
);

    import cbz_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = T_FRAC_BITS;
    localparam int W1 = W + F;
    localparam int W2 = W + 2 * F;
    localparam int W3 = W + 3 * F;
    localparam int TW = W2 + 3;

    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    logic [W-1:0]                ctrl_reg [NUM_CTRL_REGS];
    logic signed [W-1:0]         ctrl_pt [2][4];

    logic [NUM_STAGES-1:0]       valid_reg;
    logic [NUM_STAGES-1:0]       load;

    logic [F:0]                  t_next;
    logic [F:0]                  t_reg [3];
    logic [F:0]                  u_reg [3];

    logic signed [W1-1:0]        lvl1 [2][3];
    logic signed [W2-1:0]        lvl2 [2][2];
    logic signed [W3-1:0]        lvl3 [2];
    logic signed [TW-1:0]        tan_next [2];
    logic signed [TW-1:0]        tan_reg [2];

    logic [W-1:0]                pt_rs [2];
    logic [W-1:0]                tg_rs [2];
    logic [1:0]                  pt_clip;
    logic [1:0]                  tg_clip;

    logic [W-1:0]                point_x_reg;
    logic [W-1:0]                point_y_reg;
    logic [W-1:0]                tangent_x_reg;
    logic [W-1:0]                tangent_y_reg;
    logic                        sat_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTRL_REGS; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_CTRL_REGS)))
        begin
            ctrl_reg[cfg_index[CTRL_SEL_W-1:0]] <= cfg_data;
        end
    end

    assign ctrl_pt[0][0] = signed'(ctrl_reg[CTRL_X0[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[1][0] = signed'(ctrl_reg[CTRL_Y0[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[0][1] = signed'(ctrl_reg[CTRL_X1[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[1][1] = signed'(ctrl_reg[CTRL_Y1[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[0][2] = signed'(ctrl_reg[CTRL_X2[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[1][2] = signed'(ctrl_reg[CTRL_Y2[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[0][3] = signed'(ctrl_reg[CTRL_X3[CTRL_SEL_W-1:0]]);
    assign ctrl_pt[1][3] = signed'(ctrl_reg[CTRL_Y3[CTRL_SEL_W-1:0]]);

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: clamp t and form u = 1 - t.
    assign t_next = (param_t > T_ONE) ? T_ONE : param_t;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            t_reg[0] <= t_next;
            u_reg[0] <= T_ONE - t_next;
        end
        if (load[1])
        begin
            t_reg[1] <= t_reg[0];
            u_reg[1] <= u_reg[0];
        end
        if (load[2])
        begin
            t_reg[2] <= t_reg[1];
            u_reg[2] <= u_reg[1];
        end
    end

    // Stages 1 to 3: de Casteljau levels, each scaled by a further 2^F.
    for (genvar ax = 0; ax < 2; ax++)
    begin : g_axis
        for (genvar i = 0; i < 3; i++)
        begin : g_lvl1
            cbz_lerp #(.IN_W(W), .F(F)) u_lerp (
                .clk   (clk),
                .load  (load[1]),
                .a_val (ctrl_pt[ax][i]),
                .b_val (ctrl_pt[ax][i+1]),
                .t_val (t_reg[0]),
                .u_val (u_reg[0]),
                .q_val (lvl1[ax][i])
            );
        end

        for (genvar i = 0; i < 2; i++)
        begin : g_lvl2
            cbz_lerp #(.IN_W(W1), .F(F)) u_lerp (
                .clk   (clk),
                .load  (load[2]),
                .a_val (lvl1[ax][i]),
                .b_val (lvl1[ax][i+1]),
                .t_val (t_reg[1]),
                .u_val (u_reg[1]),
                .q_val (lvl2[ax][i])
            );
        end

        cbz_lerp #(.IN_W(W2), .F(F)) u_lvl3 (
            .clk   (clk),
            .load  (load[3]),
            .a_val (lvl2[ax][0]),
            .b_val (lvl2[ax][1]),
            .t_val (t_reg[2]),
            .u_val (u_reg[2]),
            .q_val (lvl3[ax])
        );

        // The derivative is three times the difference of the second level.
        always_comb
        begin
            tan_next[ax] = TW'(lvl2[ax][1]) - TW'(lvl2[ax][0]);
            tan_next[ax] = (tan_next[ax] <<< 1) + tan_next[ax];
        end

        always_ff @(posedge clk)
        begin
            if (load[3])
            begin
                tan_reg[ax] <= tan_next[ax];
            end
        end

        // Stage 4: rounding and clipping feed the output register.
        cbz_round_sat #(.IN_W(W3), .SHIFT(3 * F), .OUT_W(W)) u_pt_rs (
            .value_in  (lvl3[ax]),
            .value_out (pt_rs[ax]),
            .clipped   (pt_clip[ax])
        );

        cbz_round_sat #(.IN_W(TW), .SHIFT(2 * F), .OUT_W(W)) u_tg_rs (
            .value_in  (tan_reg[ax]),
            .value_out (tg_rs[ax]),
            .clipped   (tg_clip[ax])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            point_x_reg   <= pt_rs[0];
            point_y_reg   <= pt_rs[1];
            tangent_x_reg <= tg_rs[0];
            tangent_y_reg <= tg_rs[1];
            sat_reg       <= (|pt_clip) || (|tg_clip);
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign tangent_x = tangent_x_reg;
    assign tangent_y = tangent_y_reg;
    assign saturated = sat_reg;

    // The input side stalls only when every stage is full and the output is held.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> ((&valid_reg) && !out_ready)
    ) else $error("input stalled while the pipeline has room");

    // The clamped parameter and its complement always add up to one.
    a_t_plus_u_one: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> ((t_reg[0] + u_reg[0]) == (F + 1)'(T_ONE))
    ) else $error("t and u do not sum to one");

    // A point is a convex combination of the control points and never clips.
    a_point_never_clips: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (pt_clip == 2'b00)
    ) else $error("curve point clipped");

    // An accepted transaction always lands in the first stage.
    a_accept_fills_stage0: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0]
    ) else $error("accepted transaction lost at stage 0");

endmodule

// ----- tb/sv/tb_cubic_bezier_point_tangent_unit.sv -----
// Self-checking testbench for the cubic Bezier point and tangent unit.
`timescale 1ns / 1ps

module tb_cubic_bezier_point_tangent_unit;

    import cbz_pkg::*;

    localparam int COORD_W = 32;
    localparam int T_FRAC  = 16;
    localparam logic [T_FRAC:0] T_ONE = 17'h10000;

    localparam logic signed [127:0] COORD_MAX = 128'sd2147483647;
    localparam logic signed [127:0] COORD_MIN = -128'sd2147483648;
    localparam logic [COORD_W-1:0] MAX_COORD_BITS = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] MIN_COORD_BITS = 32'h8000_0000;

    localparam int RANDOM_SETS  = 8;
    localparam int SET_LENGTH   = 200;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] tangent_x;
        logic [COORD_W-1:0] tangent_y;
        logic               saturated;
    } bezier_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COORD_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [T_FRAC:0]        param_t;
    logic                   out_valid;
    logic                   out_ready;
    logic [COORD_W-1:0]     point_x;
    logic [COORD_W-1:0]     point_y;
    logic [COORD_W-1:0]     tangent_x;
    logic [COORD_W-1:0]     tangent_y;
    logic                   saturated;

    // Our own copy of the control point registers.
    logic signed [COORD_W-1:0] ctrl_points [NUM_CTRL_REGS];

    bezier_result_t pending_results [$];
    bezier_result_t head;

    bit full_speed;
    int stall_left;
    int fail_count;
    int checked_count;
    int clipped_count;
    int param_count;
    int curve_count;

    cubic_bezier_point_tangent_unit #(
        .COORD_WIDTH (COORD_W),
        .T_FRAC_BITS (T_FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .param_t   (param_t),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .tangent_x (tangent_x),
        .tangent_y (tangent_y),
        .saturated (saturated)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Divide by 2^shift rounding half up, then clip; bit 32 flags a clip.
    function automatic logic [32:0] round_clip(input logic signed [127:0] acc,
                                               input int shift);
        logic signed [127:0] q;
        q = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
        if (q > COORD_MAX)
            return {1'b1, COORD_MAX[COORD_W-1:0]};
        if (q < COORD_MIN)
            return {1'b1, COORD_MIN[COORD_W-1:0]};
        return {1'b0, q[COORD_W-1:0]};
    endfunction

    // Exact Bernstein sums for the point (scaled by S^3) and tangent (S^2).
    function automatic bezier_result_t eval_bezier(input logic [T_FRAC:0] t_raw);
        bezier_result_t r;
        logic signed [127:0] tw, u, p0, p1, p2, p3, pt_sum, tg_sum;
        logic [32:0] pt_q, tg_q;
        logic [CTRL_SEL_W-1:0] ax;
        r = '0;
        tw = 128'((t_raw > T_ONE) ? T_ONE : t_raw);
        u = (128'sd1 <<< T_FRAC) - tw;
        for (int axis = 0; axis < 2; axis++)
        begin
            ax = CTRL_SEL_W'(axis);
            p0 = 128'(ctrl_points[CTRL_X0[CTRL_SEL_W-1:0] + ax]);
            p1 = 128'(ctrl_points[CTRL_X1[CTRL_SEL_W-1:0] + ax]);
            p2 = 128'(ctrl_points[CTRL_X2[CTRL_SEL_W-1:0] + ax]);
            p3 = 128'(ctrl_points[CTRL_X3[CTRL_SEL_W-1:0] + ax]);
            pt_sum = p0 * u * u * u + p1 * 3 * tw * u * u
                   + p2 * 3 * tw * tw * u + p3 * tw * tw * tw;
            tg_sum = -3 * p0 * u * u + 3 * p1 * u * u - 6 * p1 * tw * u
                   + 6 * p2 * tw * u - 3 * p2 * tw * tw + 3 * p3 * tw * tw;
            pt_q = round_clip(pt_sum, 3 * T_FRAC);
            tg_q = round_clip(tg_sum, 2 * T_FRAC);
            if (axis == 0)
            begin
                r.point_x   = pt_q[COORD_W-1:0];
                r.tangent_x = tg_q[COORD_W-1:0];
            end
            else
            begin
                r.point_y   = pt_q[COORD_W-1:0];
                r.tangent_y = tg_q[COORD_W-1:0];
            end
            r.saturated = r.saturated | pt_q[32] | tg_q[32];
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return MAX_COORD_BITS;
            1: return MIN_COORD_BITS;
            2, 3, 4: return $urandom;
            default: return COORD_W'($urandom_range(0, 2_000_000)) - 32'd1_000_000;
        endcase
    endfunction

    function automatic logic [T_FRAC:0] pick_param();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return (T_FRAC + 1)'($urandom_range(0, T_ONE));
        if (roll < 80)
            return ($urandom_range(0, 1) != 0) ? T_ONE : '0;
        if (roll < 90)
            return (T_FRAC + 1)'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
        if (roll < 95)
            return (T_FRAC + 1)'($urandom_range(0, 15));
        return T_ONE - (T_FRAC + 1)'($urandom_range(0, 15));
    endfunction

    task automatic send_param(input logic [T_FRAC:0] t);
        int gap;
        gap = full_speed ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        param_t  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results = {pending_results, eval_bezier(t)};
        param_count++;
    endtask

    // Stop offering parameters and wait until every result has come back.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES) @(posedge clk);
    endtask

    task automatic write_ctrl(input logic [CFG_INDEX_W-1:0] index,
                              input logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index < NUM_CTRL_REGS)
            ctrl_points[index[CTRL_SEL_W-1:0]] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_curve(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                               input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                               input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2,
                               input logic [COORD_W-1:0] x3, input logic [COORD_W-1:0] y3);
        drain_pipeline();
        write_ctrl(CTRL_X0, x0);
        write_ctrl(CTRL_Y0, y0);
        write_ctrl(CTRL_X1, x1);
        write_ctrl(CTRL_Y1, y1);
        write_ctrl(CTRL_X2, x2);
        write_ctrl(CTRL_Y2, y2);
        write_ctrl(CTRL_X3, x3);
        write_ctrl(CTRL_Y3, y3);
        curve_count++;
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] expected,
                               input logic [COORD_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %h, got %h", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("output transaction with no parameter outstanding");
                fail_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("point_x", head.point_x, point_x);
                check_field("point_y", head.point_y, point_y);
                check_field("tangent_x", head.tangent_x, tangent_x);
                check_field("tangent_y", head.tangent_y, tangent_y);
                check_field("saturated", COORD_W'(head.saturated), COORD_W'(saturated));
                checked_count++;
                if (head.saturated)
                    clipped_count++;
            end
        end
    end

    // Downstream back-pressure: random stalls unless running at full speed.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!full_speed)
                    stall_left = pick_gap();
            end
        end
    end

    // Control points come out of reset as zero, so every result is zero.
    task automatic test_reset_state();
        send_param('0);
        send_param(T_ONE >> 1);
        send_param(T_ONE);
    endtask

    // Distinct values per register, then writes beyond the map must be ignored.
    task automatic test_register_map();
        write_curve(32'h0001_0000, 32'hfffe_0000, 32'h0003_8000, 32'h0004_0000,
                    32'hfffb_0000, 32'h0006_4000, 32'h0007_0000, 32'hfff8_0000);
        send_param(T_ONE >> 2);
        drain_pipeline();
        write_ctrl(CFG_INDEX_W'(NUM_CTRL_REGS), 32'hdead_beef);
        write_ctrl({CFG_INDEX_W{1'b1}}, 32'h1234_5678);
        send_param(T_ONE >> 2);
        send_param(T_ONE - 1);
        send_param(17'd1);
    endtask

    // Full-scale controls: points never clip; the second curve's tangent does.
    task automatic test_extreme_controls();
        write_curve(MAX_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS,
                    MAX_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS);
        send_param('0);
        send_param(17'd1);
        send_param(T_ONE - 1);
        send_param(T_ONE);
        send_param(T_ONE + 1);
        send_param({(T_FRAC + 1){1'b1}});
        write_curve(MIN_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS, MIN_COORD_BITS,
                    MIN_COORD_BITS, MAX_COORD_BITS, MAX_COORD_BITS, MIN_COORD_BITS);
        send_param('0);
        send_param(T_ONE >> 1);
        send_param(T_ONE);
        send_param(17'h1_5555);
        send_param(17'h0_aaaa);
        send_param(17'h0_5555);
    endtask

    task automatic test_random_curves();
        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            write_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord(), pick_coord());
            full_speed = (set % 3 == 1);
            for (int n = 0; n < SET_LENGTH; n++)
            begin
                // Let the pipeline empty completely once per curve.
                if (n == SET_LENGTH / 2)
                    drain_pipeline();
                send_param(pick_param());
            end
            full_speed = 1'b0;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        param_t    = '0;
        full_speed = 1'b0;
        fail_count = 0;
        checked_count = 0;
        clipped_count = 0;
        param_count   = 0;
        curve_count   = 0;
        for (int i = 0; i < NUM_CTRL_REGS; i++)
            ctrl_points[i] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_map();
        test_extreme_controls();
        test_random_curves();
        drain_pipeline();

        $display("Checked %0d results for %0d parameter values over %0d control point sets.",
                 checked_count, param_count, curve_count);
        $display("%0d of those results had at least one output clipped.", clipped_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
